// ===== rtl/core/sklt_pkg.sv =====
// Shared types and constants for the sorted keyed line table.
// Holds the channel payload structs, the command and status codes and the
// control and status bundles between the controller and the datapath.
`timescale 1ns / 1ps

package sklt_pkg;

    // Fixed field widths of the two channels.
    localparam int CMD_W     = 3;
    localparam int KEY_W     = 16;
    localparam int HANDLE_W  = 32;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 9;
    localparam int FILL_W    = 9;
    localparam int PAYLOAD_MAX_W = 64;

    // Defaults of the top-level parameters.
    localparam int DEF_TABLE_DEPTH  = 256;
    localparam int DEF_PAYLOAD_BITS = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_STORE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [KEY_W-1:0]    line_number;
        logic [HANDLE_W-1:0] text_handle;
        logic [POS_W-1:0]    position;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  entry_index;
        logic [KEY_W-1:0]    entry_key;
        logic [HANDLE_W-1:0] entry_payload;
        logic [FILL_W-1:0]   fill_level;
    } t_out_item;

    // Source of the table read address.
    typedef enum logic [1:0] {
        RD_MID,
        RD_LO,
        RD_POS,
        RD_SHIFT
    } t_rd_sel;

    // Which result the datapath captures.
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_MISS,
        RES_FULL,
        RES_HIT,
        RES_STORED,
        RES_POS
    } t_res_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_item;
        logic      search_init;
        logic      search_step;
        logic      rd_en;
        t_rd_sel   rd_sel;
        logic      wr_new;
        logic      wr_shift;
        logic      shift_init_up;
        logic      shift_init_down;
        logic      count_inc;
        logic      count_dec;
        logic      count_clr;
        logic      res_load;
        t_res_kind res_kind;
        logic      out_load;
    } t_sklt_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             search_more;
        logic             hit;
        logic             full;
        logic             pos_ok;
        logic             shift_more;
        logic             out_busy;
    } t_sklt_sts;

endpackage

// ===== rtl/core/sklt_datapath.sv =====
// Datapath of the sorted keyed line table: entry memory, entry count,
// binary search bounds, shift cursor, result hold and output register.
// Depends on sklt_pkg for the payload structs and the control bundles.
`timescale 1ns / 1ps

module sklt_datapath #(
    parameter int TABLE_DEPTH  = sklt_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_BITS = sklt_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sklt_pkg::t_in_item  i_in_item,
    input  sklt_pkg::t_sklt_ctl i_ctl,
    input  logic                i_out_ready,
    output sklt_pkg::t_sklt_sts o_sts,
    output logic                o_out_valid,
    output sklt_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = sklt_pkg::KEY_W + PAYLOAD_BITS;
    localparam int XW = (CW > sklt_pkg::INDEX_W) ? CW : sklt_pkg::INDEX_W;

    // Item under work and table state.
    sklt_pkg::t_in_item r_item;
    logic [EW-1:0]      r_mem [TABLE_DEPTH];
    logic [EW-1:0]      r_rd;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic [CW-1:0]      r_cur;
    logic               r_up;

    // Result held until it is moved to the output register.
    logic [sklt_pkg::STATUS_W-1:0] r_res_status;
    logic [sklt_pkg::INDEX_W-1:0]  r_res_index;
    logic [sklt_pkg::KEY_W-1:0]    r_res_key;
    logic [sklt_pkg::HANDLE_W-1:0] r_res_payload;

    sklt_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [CW:0]                        w_mid_sum;
    logic [CW-1:0]                      w_mid;
    logic [sklt_pkg::KEY_W-1:0]         w_rd_key;
    logic [PAYLOAD_BITS-1:0]            w_rd_pay;
    logic [sklt_pkg::PAYLOAD_MAX_W-1:0] w_handle_x;
    logic [PAYLOAD_BITS-1:0]            w_new_pay;
    logic [sklt_pkg::PAYLOAD_MAX_W-1:0] w_rd_pay_x;
    logic [sklt_pkg::PAYLOAD_MAX_W-1:0] w_new_pay_x;
    logic [XW-1:0]                      w_pos_x;
    logic [XW-1:0]                      w_count_x;
    logic [XW-1:0]                      w_lo_x;
    logic [CW:0]                        w_cur_inc;
    logic [CW-1:0]                      w_cur_dec;
    logic [CW-1:0]                      w_src;
    logic [AW-1:0]                      w_rd_addr;
    logic                               w_wr_en;
    logic [AW-1:0]                      w_wr_addr;
    logic [EW-1:0]                      w_wr_data;

    // Field views and width adjustments.
    assign w_mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid       = w_mid_sum[CW:1];
    assign w_rd_key    = r_rd[EW-1 -: sklt_pkg::KEY_W];
    assign w_rd_pay    = r_rd[PAYLOAD_BITS-1:0];
    assign w_handle_x  = sklt_pkg::PAYLOAD_MAX_W'(r_item.text_handle);
    assign w_new_pay   = w_handle_x[PAYLOAD_BITS-1:0];
    assign w_rd_pay_x  = sklt_pkg::PAYLOAD_MAX_W'(w_rd_pay);
    assign w_new_pay_x = sklt_pkg::PAYLOAD_MAX_W'(w_new_pay);
    assign w_pos_x     = XW'(r_item.position);
    assign w_count_x   = XW'(r_count);
    assign w_lo_x      = XW'(r_lo);

    // Shift cursor neighbors: the source entry sits below or above the cursor.
    assign w_cur_inc = {1'b0, r_cur} + 1'b1;
    assign w_cur_dec = r_cur - 1'b1;
    assign w_src     = r_up ? w_cur_dec : w_cur_inc[CW-1:0];

    // Status toward the controller.
    always_comb begin
        o_sts.command     = r_item.command;
        o_sts.search_more = (r_lo < r_hi);
        o_sts.hit         = (r_lo < r_count) && (w_rd_key == r_item.line_number);
        o_sts.full        = (r_count == CW'(TABLE_DEPTH));
        o_sts.pos_ok      = (w_pos_x < w_count_x);
        o_sts.shift_more  = r_up ? (r_cur > r_lo) : (w_cur_inc < {1'b0, r_count});
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

    // Read address selection.
    always_comb begin
        case (i_ctl.rd_sel)
            sklt_pkg::RD_MID:   w_rd_addr = w_mid[AW-1:0];
            sklt_pkg::RD_LO:    w_rd_addr = r_lo[AW-1:0];
            sklt_pkg::RD_POS:   w_rd_addr = w_pos_x[AW-1:0];
            sklt_pkg::RD_SHIFT: w_rd_addr = w_src[AW-1:0];
            default:            w_rd_addr = r_lo[AW-1:0];
        endcase
    end

    // Write port: a new or replaced entry goes to the search position,
    // a shifted entry goes to the cursor.
    always_comb begin
        w_wr_en   = i_ctl.wr_new || i_ctl.wr_shift;
        w_wr_addr = r_cur[AW-1:0];
        w_wr_data = r_rd;
        if (i_ctl.wr_new) begin
            w_wr_addr = r_lo[AW-1:0];
            w_wr_data = {r_item.line_number, w_new_pay};
        end
    end

    // Entry memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Captured item.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) begin
            r_item <= i_in_item;
        end
    end

    // Binary search bounds for the first key not below the item key.
    always_ff @(posedge i_clk) begin
        if (i_ctl.search_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_ctl.search_step) begin
            if (w_rd_key < r_item.line_number) begin
                r_lo <= w_mid + 1'b1;
            end else begin
                r_hi <= w_mid;
            end
        end
    end

    // Shift cursor: moves down for an insert, up for a delete.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_init_up) begin
            r_cur <= r_count;
            r_up  <= 1'b1;
        end else if (i_ctl.shift_init_down) begin
            r_cur <= r_lo;
            r_up  <= 1'b0;
        end else if (i_ctl.wr_shift) begin
            r_cur <= w_src;
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.count_clr) begin
            r_count <= '0;
        end else if (i_ctl.count_inc) begin
            r_count <= r_count + 1'b1;
        end else if (i_ctl.count_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Result hold, loaded at the decision point of each command.
    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_res_status  <= sklt_pkg::STATUS_OK;
            r_res_index   <= '0;
            r_res_key     <= '0;
            r_res_payload <= '0;
            case (i_ctl.res_kind)
                sklt_pkg::RES_MISS: begin
                    r_res_status <= sklt_pkg::STATUS_MISSING;
                end
                sklt_pkg::RES_FULL: begin
                    r_res_status <= sklt_pkg::STATUS_FULL;
                    r_res_index  <= w_lo_x[sklt_pkg::INDEX_W-1:0];
                end
                sklt_pkg::RES_HIT: begin
                    r_res_index   <= w_lo_x[sklt_pkg::INDEX_W-1:0];
                    r_res_key     <= w_rd_key;
                    r_res_payload <= w_rd_pay_x[sklt_pkg::HANDLE_W-1:0];
                end
                sklt_pkg::RES_STORED: begin
                    r_res_index   <= w_lo_x[sklt_pkg::INDEX_W-1:0];
                    r_res_key     <= r_item.line_number;
                    r_res_payload <= w_new_pay_x[sklt_pkg::HANDLE_W-1:0];
                end
                sklt_pkg::RES_POS: begin
                    r_res_index   <= w_pos_x[sklt_pkg::INDEX_W-1:0];
                    r_res_key     <= w_rd_key;
                    r_res_payload <= w_rd_pay_x[sklt_pkg::HANDLE_W-1:0];
                end
                default: begin
                    r_res_status <= sklt_pkg::STATUS_OK;
                end
            endcase
        end
    end

    // Output register; the fill level is taken once the count is final.
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out.status        <= r_res_status;
            r_out.entry_index   <= r_res_index;
            r_out.entry_key     <= r_res_key;
            r_out.entry_payload <= r_res_payload;
            r_out.fill_level    <= w_count_x[sklt_pkg::FILL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/core/sklt_ctrl.sv =====
// Controller of the sorted keyed line table: sequences search, probe,
// shift and result transfer for one command at a time.
// Depends on sklt_pkg for the control and status bundles and command codes.
`timescale 1ns / 1ps

module sklt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sklt_pkg::t_sklt_sts i_sts,
    output sklt_pkg::t_sklt_ctl o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_COMPARE,
        S_PROBE,
        S_CHECK,
        S_POS,
        S_SHIFT,
        S_MOVE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.command)
                    sklt_pkg::CMD_STORE, sklt_pkg::CMD_DELETE, sklt_pkg::CMD_FIND: begin
                        o_ctl.search_init = 1'b1;
                        n_state           = S_SEARCH;
                    end
                    sklt_pkg::CMD_READ: begin
                        if (i_sts.pos_ok) begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = sklt_pkg::RD_POS;
                            n_state      = S_POS;
                        end else begin
                            o_ctl.res_load = 1'b1;
                            o_ctl.res_kind = sklt_pkg::RES_MISS;
                            n_state        = S_DONE;
                        end
                    end
                    sklt_pkg::CMD_CLEAR: begin
                        o_ctl.count_clr = 1'b1;
                        o_ctl.res_load  = 1'b1;
                        o_ctl.res_kind  = sklt_pkg::RES_ZERO;
                        n_state         = S_DONE;
                    end
                    default: begin
                        o_ctl.res_load = 1'b1;
                        o_ctl.res_kind = sklt_pkg::RES_ZERO;
                        n_state        = S_DONE;
                    end
                endcase
            end
            // One binary search step: read the middle entry, then narrow.
            S_SEARCH: begin
                if (i_sts.search_more) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = sklt_pkg::RD_MID;
                    n_state      = S_COMPARE;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_COMPARE: begin
                o_ctl.search_step = 1'b1;
                n_state           = S_SEARCH;
            end
            // Read the entry at the found position to test for a match.
            S_PROBE: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_sel = sklt_pkg::RD_LO;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_ctl.res_load = 1'b1;
                n_state        = S_DONE;
                case (i_sts.command)
                    sklt_pkg::CMD_STORE: begin
                        if (i_sts.hit) begin
                            o_ctl.wr_new   = 1'b1;
                            o_ctl.res_kind = sklt_pkg::RES_STORED;
                        end else if (!i_sts.full) begin
                            o_ctl.res_kind      = sklt_pkg::RES_STORED;
                            o_ctl.shift_init_up = 1'b1;
                            n_state             = S_SHIFT;
                        end else begin
                            o_ctl.res_kind = sklt_pkg::RES_FULL;
                        end
                    end
                    sklt_pkg::CMD_DELETE: begin
                        if (i_sts.hit) begin
                            o_ctl.res_kind        = sklt_pkg::RES_HIT;
                            o_ctl.shift_init_down = 1'b1;
                            n_state               = S_SHIFT;
                        end else begin
                            o_ctl.res_kind = sklt_pkg::RES_MISS;
                        end
                    end
                    default: begin
                        o_ctl.res_kind = i_sts.hit ? sklt_pkg::RES_HIT : sklt_pkg::RES_MISS;
                    end
                endcase
            end
            S_POS: begin
                o_ctl.res_load = 1'b1;
                o_ctl.res_kind = sklt_pkg::RES_POS;
                n_state        = S_DONE;
            end
            // Move one entry per pass through S_SHIFT and S_MOVE; finish the edit when none is left.
            S_SHIFT: begin
                if (i_sts.shift_more) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = sklt_pkg::RD_SHIFT;
                    n_state      = S_MOVE;
                end else begin
                    if (i_sts.command == sklt_pkg::CMD_STORE) begin
                        o_ctl.wr_new    = 1'b1;
                        o_ctl.count_inc = 1'b1;
                    end else begin
                        o_ctl.count_dec = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_MOVE: begin
                o_ctl.wr_shift = 1'b1;
                n_state        = S_SHIFT;
            end
            // Hand the result over once the output register is free.
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/sorted_keyed_line_table.sv =====
// Top level of the sorted keyed line table.
// Joins the controller sklt_ctrl and the datapath sklt_datapath; uses sklt_pkg.
//
//   Channel   Handshake                    Payload
//   input     i_in_valid / o_in_ready      i_in_item  (sklt_pkg::t_in_item)
//   output    o_out_valid / i_out_ready    o_out_item (sklt_pkg::t_out_item)
//
// One command at a time. Store, delete and find run a binary search over the entry
// memory, each step a read in S_SEARCH and a narrowing in S_COMPARE, with at most
// ceil(log2(n+1)) steps for n entries. An insert or a removal then moves entries one
// by one through S_SHIFT and S_MOVE. Read fetches its entry by position directly.
// Reset is synchronous and empties the table; memory contents are not cleared.
// A new command is accepted while the previous result still waits in the
// output register; a finished command holds until that register is free.
`timescale 1ns / 1ps

module sorted_keyed_line_table #(
    parameter int TABLE_DEPTH  = sklt_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_BITS = sklt_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sklt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sklt_pkg::t_out_item o_out_item
);

    sklt_pkg::t_sklt_ctl w_ctl;
    sklt_pkg::t_sklt_sts w_sts;

    // Command sequencer.
    sklt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // Entry storage and result path.
    sklt_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_ctl       (w_ctl),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/sorted_keyed_line_table_tb.sv =====
// Self-checking testbench for the sorted keyed line table.
// Drives commands through the input channel, predicts each result with a shadow
// copy of the table and checks the output channel; depends on sklt_pkg and the RTL.
`timescale 1ns / 1ps

module sorted_keyed_line_table_tb;

    localparam int LINE_DEPTH     = sklt_pkg::DEF_TABLE_DEPTH;
    localparam int KEY_POOL_SPAN  = 47;
    localparam int SETTLE_CYCLES  = 600;

    // Command values that the block ignores.
    localparam logic [sklt_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [sklt_pkg::CMD_W-1:0] CMD_UNUSED_MID   = 3'd6;
    localparam logic [sklt_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    sklt_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    sklt_pkg::t_out_item o_out_item;

    // Shadow copy of the table contents.
    logic [sklt_pkg::KEY_W-1:0]    line_keys [LINE_DEPTH];
    logic [sklt_pkg::HANDLE_W-1:0] line_handles [LINE_DEPTH];
    int                            line_count;

    sklt_pkg::t_out_item pending_line_results [$];
    sklt_pkg::t_out_item want_result;
    int                  mismatch_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    sorted_keyed_line_table #(
        .TABLE_DEPTH (sklt_pkg::DEF_TABLE_DEPTH),
        .PAYLOAD_BITS(sklt_pkg::DEF_PAYLOAD_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // Free-running clock, 10 ns period.
    always #5 i_clk = ~i_clk;

    // Applies one command to the shadow table and returns the result it gives.
    function automatic sklt_pkg::t_out_item line_table_result(
        input sklt_pkg::t_in_item cmd_item
    );
        sklt_pkg::t_out_item res;
        int                  slot;
        int                  i;
        logic                hit;
        res  = '0;
        slot = 0;
        while (slot < line_count && line_keys[slot] < cmd_item.line_number) slot++;
        hit = (slot < line_count) && (line_keys[slot] == cmd_item.line_number);
        case (cmd_item.command)
            sklt_pkg::CMD_STORE: begin
                if (hit || line_count < LINE_DEPTH) begin
                    if (!hit) begin
                        for (i = line_count; i > slot; i--) begin
                            line_keys[i]    = line_keys[i-1];
                            line_handles[i] = line_handles[i-1];
                        end
                        line_keys[slot] = cmd_item.line_number;
                        line_count++;
                    end
                    line_handles[slot] = cmd_item.text_handle;
                    res.entry_index    = sklt_pkg::INDEX_W'(slot);
                    res.entry_key      = cmd_item.line_number;
                    res.entry_payload  = cmd_item.text_handle;
                end else begin
                    // Table full: the new key is dropped, only its place is reported.
                    res.status      = sklt_pkg::STATUS_FULL;
                    res.entry_index = sklt_pkg::INDEX_W'(slot);
                end
            end
            sklt_pkg::CMD_DELETE: begin
                if (!hit) begin
                    res.status = sklt_pkg::STATUS_MISSING;
                end else begin
                    res.entry_index   = sklt_pkg::INDEX_W'(slot);
                    res.entry_key     = line_keys[slot];
                    res.entry_payload = line_handles[slot];
                    for (i = slot; i + 1 < line_count; i++) begin
                        line_keys[i]    = line_keys[i+1];
                        line_handles[i] = line_handles[i+1];
                    end
                    line_count--;
                end
            end
            sklt_pkg::CMD_FIND: begin
                if (!hit) begin
                    res.status = sklt_pkg::STATUS_MISSING;
                end else begin
                    res.entry_index   = sklt_pkg::INDEX_W'(slot);
                    res.entry_key     = line_keys[slot];
                    res.entry_payload = line_handles[slot];
                end
            end
            sklt_pkg::CMD_READ: begin
                if (int'(cmd_item.position) >= line_count) begin
                    res.status = sklt_pkg::STATUS_MISSING;
                end else begin
                    res.entry_index   = sklt_pkg::INDEX_W'(cmd_item.position);
                    res.entry_key     = line_keys[cmd_item.position];
                    res.entry_payload = line_handles[cmd_item.position];
                end
            end
            sklt_pkg::CMD_CLEAR: begin
                line_count = 0;
            end
            default: begin
            end
        endcase
        res.fill_level = sklt_pkg::FILL_W'(line_count);
        return res;
    endfunction

    function automatic sklt_pkg::t_in_item make_cmd(
        input logic [sklt_pkg::CMD_W-1:0]    command,
        input logic [sklt_pkg::KEY_W-1:0]    key,
        input logic [sklt_pkg::HANDLE_W-1:0] handle,
        input logic [sklt_pkg::POS_W-1:0]    pos
    );
        sklt_pkg::t_in_item cmd_item;
        cmd_item.command     = command;
        cmd_item.line_number = key;
        cmd_item.text_handle = handle;
        cmd_item.position    = pos;
        return cmd_item;
    endfunction

    // Sends one command, with a random gap before it, and records its result.
    task automatic send_command(input sklt_pkg::t_in_item cmd_item);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= cmd_item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_line_results.push_back(line_table_result(cmd_item));
    endtask

    // Holds the sender off until every outstanding result has been checked.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_line_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(
        input string       field_name,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver side: random back-pressure on the output channel.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every output transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_line_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                         $time, o_out_item);
                mismatch_count++;
            end else begin
                want_result = pending_line_results.pop_front();
                report_field("status", 32'(want_result.status), 32'(o_out_item.status));
                report_field("entry_index", 32'(want_result.entry_index),
                             32'(o_out_item.entry_index));
                report_field("entry_key", 32'(want_result.entry_key),
                             32'(o_out_item.entry_key));
                report_field("entry_payload", want_result.entry_payload,
                             o_out_item.entry_payload);
                report_field("fill_level", 32'(want_result.fill_level),
                             32'(o_out_item.fill_level));
            end
        end
    end

    // Empty table, edge keys and payloads, every command and the ignored codes.
    task automatic test_directed_edges();
        send_command(make_cmd(sklt_pkg::CMD_FIND, 16'd0, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_DELETE, 16'd5, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'd1000, 32'hA5A5_5A5A, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'd0, 32'h0000_0000, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'd500, 32'h0F0F_F0F0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'd1000, 32'h1234_5678, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_FIND, 16'd1000, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_FIND, 16'd999, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'd3));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'd4));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
        send_command(make_cmd(sklt_pkg::CMD_DELETE, 16'd500, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_DELETE, 16'd500, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_DELETE, 16'hFFFF, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_FIND, 16'd0, 32'd0, 8'd0));
        send_command(make_cmd(CMD_UNUSED_FIRST, 16'($urandom), $urandom, 8'($urandom)));
        send_command(make_cmd(CMD_UNUSED_MID, 16'd1000, $urandom, 8'd0));
        send_command(make_cmd(CMD_UNUSED_LAST, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
        send_command(make_cmd(sklt_pkg::CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
        send_command(make_cmd(sklt_pkg::CMD_FIND, 16'd1000, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'd1000, 32'hDEAD_0001, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'd0));
    endtask

    // Fills the table to capacity, then exercises the full case and the long shifts.
    task automatic test_full_table();
        int i;
        send_command(make_cmd(sklt_pkg::CMD_CLEAR, 16'd0, 32'd0, 8'd0));
        // Ascending keys append at the end, so the fill itself moves nothing.
        for (i = 0; i < LINE_DEPTH; i++) begin
            send_command(make_cmd(sklt_pkg::CMD_STORE, {i[7:0], 8'h80}, $urandom,
                                  8'($urandom)));
        end
        wait_for_results();
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'hFFFF, $urandom, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'h0000, $urandom, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'h0080, $urandom, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_FIND, 16'hFF80, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'hFF));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'd0));
        for (i = 0; i < 8; i++) begin
            send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'($urandom)));
        end
        send_command(make_cmd(sklt_pkg::CMD_DELETE, 16'h0080, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'd5, $urandom, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'd7, $urandom, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_DELETE, 16'hFF80, 32'd0, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'hFF));
        send_command(make_cmd(sklt_pkg::CMD_STORE, 16'hFFFF, $urandom, 8'd0));
        send_command(make_cmd(sklt_pkg::CMD_READ, 16'd0, 32'd0, 8'hFF));
        send_command(make_cmd(sklt_pkg::CMD_CLEAR, 16'd0, 32'd0, 8'd0));
    endtask

    // Mostly keys that exist or sit in a small window, so hits and misses both occur.
    function automatic logic [sklt_pkg::KEY_W-1:0] pick_line_key(input int pool_base);
        int r;
        r = $urandom_range(99);
        if (r < 45 && line_count > 0)
            return line_keys[$urandom_range(line_count - 1)];
        else if (r < 90)
            return sklt_pkg::KEY_W'(pool_base + $urandom_range(KEY_POOL_SPAN));
        else
            return sklt_pkg::KEY_W'($urandom);
    endfunction

    // Random command mix at the given idle rates for sender and receiver.
    task automatic test_random_traffic(input int item_total, input int send_pct,
                                       input int recv_pct);
        int                            n;
        int                            r;
        int                            pool_base;
        logic [sklt_pkg::CMD_W-1:0]    command;
        logic [sklt_pkg::HANDLE_W-1:0] handle;
        logic [sklt_pkg::POS_W-1:0]    pos;
        wait_for_results();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        pool_base     = $urandom_range(16'hFFFF - KEY_POOL_SPAN);
        for (n = 0; n < item_total; n++) begin
            r = $urandom_range(99);
            if (r < 40)
                command = sklt_pkg::CMD_STORE;
            else if (r < 58)
                command = sklt_pkg::CMD_DELETE;
            else if (r < 76)
                command = sklt_pkg::CMD_FIND;
            else if (r < 93)
                command = sklt_pkg::CMD_READ;
            else if (r < 95)
                command = sklt_pkg::CMD_CLEAR;
            else
                command = sklt_pkg::CMD_W'($urandom_range(CMD_UNUSED_LAST,
                                                           CMD_UNUSED_FIRST));
            r = $urandom_range(99);
            if (r < 5)
                handle = '0;
            else if (r < 10)
                handle = '1;
            else
                handle = $urandom;
            // Reads mostly land on or just past the filled range.
            if ($urandom_range(99) < 80)
                pos = sklt_pkg::POS_W'((line_count > 255) ? 255
                                                          : $urandom_range(line_count));
            else
                pos = sklt_pkg::POS_W'($urandom);
            send_command(make_cmd(command, pick_line_key(pool_base), handle, pos));
        end
    endtask

    // Test sequence.
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_out_ready    = 1'b0;
        line_count     = 0;
        mismatch_count = 0;
        send_idle_pct  = 30;
        recv_idle_pct  = 69;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_full_table();
        test_random_traffic(415, 30, 69);
        test_random_traffic(415, 69, 30);
        test_random_traffic(415, 0, 0);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #100_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
